// ===== sv/vccc_pkg.sv =====
// types, corner tables and face classification shared by the cell classifier
package vccc_pkg;

  localparam int unsigned IN_LABEL_W = 16;
  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned NUM_EDGES = 12;
  localparam int unsigned NUM_FACES = 6;

  typedef logic [2:0] corner_idx_t;
  typedef logic [1:0] face_code_t;
  typedef logic [1:0] vertex_code_t;

  localparam face_code_t FACE_NONE     = 2'd0;
  localparam face_code_t FACE_SURFACE  = 2'd1;
  localparam face_code_t FACE_JUNCTION = 2'd2;

  localparam vertex_code_t VTX_NONE    = 2'd0;
  localparam vertex_code_t VTX_SURFACE = 2'd1;
  localparam vertex_code_t VTX_EDGE    = 2'd2;
  localparam vertex_code_t VTX_CORNER  = 2'd3;

  // corner pairs of the cell edges, edge 0 first
  localparam corner_idx_t EDGE_PAIR [NUM_EDGES][2] = '{
    '{3'd0, 3'd3}, '{3'd1, 3'd2}, '{3'd0, 3'd1}, '{3'd2, 3'd3},
    '{3'd4, 3'd7}, '{3'd5, 3'd6}, '{3'd4, 3'd5}, '{3'd6, 3'd7},
    '{3'd0, 3'd4}, '{3'd1, 3'd5}, '{3'd3, 3'd7}, '{3'd2, 3'd6}
  };

  // face corners in ring order: left, right, back, front, bottom, top
  localparam corner_idx_t FACE_CORNER [NUM_FACES][4] = '{
    '{3'd0, 3'd3, 3'd7, 3'd4}, '{3'd1, 3'd2, 3'd6, 3'd5},
    '{3'd0, 3'd1, 3'd5, 3'd4}, '{3'd3, 3'd2, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd4, 3'd5, 3'd6, 3'd7}
  };

  // equality flags of one face's corners a,b,c,d
  typedef struct packed {
    logic ab;
    logic ac;
    logic ad;
    logic bc;
    logic bd;
    logic cd;
  } face_eq_t;

  typedef struct packed {
    logic [IN_LABEL_W-1:0] label_0;
    logic [IN_LABEL_W-1:0] label_1;
    logic [IN_LABEL_W-1:0] label_2;
    logic [IN_LABEL_W-1:0] label_3;
    logic [IN_LABEL_W-1:0] label_4;
    logic [IN_LABEL_W-1:0] label_5;
    logic [IN_LABEL_W-1:0] label_6;
    logic [IN_LABEL_W-1:0] label_7;
  } in_word_t;

  typedef struct packed {
    logic [11:0]  edge_crossings;
    logic [11:0]  face_types;
    vertex_code_t vertex_type;
    logic [2:0]   junction_count;
  } out_word_t;

  function automatic face_code_t classify_face(input face_eq_t eq);
    logic [2:0] distinct;
    face_code_t code;
    distinct = 3'd1 + {2'b00, ~eq.ab} + {2'b00, ~eq.ac & ~eq.bc}
             + {2'b00, ~eq.ad & ~eq.bd & ~eq.cd};
    if (distinct == 3'd1) begin
      code = FACE_NONE;
    end else if (distinct == 3'd2) begin
      code = (eq.ac && eq.bd) ? FACE_JUNCTION : FACE_SURFACE;
    end else begin
      code = FACE_JUNCTION;
    end
    return code;
  endfunction

endpackage

// ===== sv/voxel_cell_crossing_classifier.sv =====
// surface-nets cell classifier: four-stage pipeline from corner labels to cell type
//
//   channel  ports                        direction  handshake
//   input    start, busy, in_word         in         start & !busy
//   result   out_valid, out_word          out        out_valid strobe
//
// one word enters every cycle; busy is held low
// a result is registered in each of the stages below in turn before it leaves
// stages: label capture, corner compares, face classification, vertex type
// synchronous active-low reset clears the valid bits only
// the receiver takes each result in its strobe cycle, so nothing waits
module voxel_cell_crossing_classifier #(
  parameter int unsigned LABEL_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  vccc_pkg::in_word_t   in_word,
  output logic                 out_valid,
  output vccc_pkg::out_word_t  out_word
);

  localparam int unsigned CMP_W =
    (LABEL_WIDTH < vccc_pkg::IN_LABEL_W) ? LABEL_WIDTH : vccc_pkg::IN_LABEL_W;

  logic [CMP_W-1:0] lab_in [vccc_pkg::NUM_CORNERS];

  logic             s1_valid_r;
  logic [CMP_W-1:0] s1_lab_r [vccc_pkg::NUM_CORNERS];

  logic                     s2_valid_r;
  logic [11:0]              s2_edges_r;
  logic [11:0]              s2_edges_nxt;
  vccc_pkg::face_eq_t       s2_eq_r  [vccc_pkg::NUM_FACES];
  vccc_pkg::face_eq_t       s2_eq_nxt [vccc_pkg::NUM_FACES];

  logic        s3_valid_r;
  logic [11:0] s3_edges_r;
  logic [11:0] s3_faces_r;
  logic [11:0] s3_faces_nxt;

  logic                out_valid_r;
  vccc_pkg::out_word_t out_word_r;
  vccc_pkg::out_word_t out_word_nxt;

  assign busy = 1'b0;

  // label capture, keeping only the compared bits
  always_comb begin
    lab_in[0] = in_word.label_0[CMP_W-1:0];
    lab_in[1] = in_word.label_1[CMP_W-1:0];
    lab_in[2] = in_word.label_2[CMP_W-1:0];
    lab_in[3] = in_word.label_3[CMP_W-1:0];
    lab_in[4] = in_word.label_4[CMP_W-1:0];
    lab_in[5] = in_word.label_5[CMP_W-1:0];
    lab_in[6] = in_word.label_6[CMP_W-1:0];
    lab_in[7] = in_word.label_7[CMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start & ~busy;
    end
    for (int i = 0; i < vccc_pkg::NUM_CORNERS; i++) begin
      s1_lab_r[i] <= lab_in[i];
    end
  end

  // corner compares
  always_comb begin
    vccc_pkg::corner_idx_t a, b, c, d;
    for (int e = 0; e < vccc_pkg::NUM_EDGES; e++) begin
      s2_edges_nxt[e] = s1_lab_r[vccc_pkg::EDGE_PAIR[e][0]]
                        != s1_lab_r[vccc_pkg::EDGE_PAIR[e][1]];
    end
    for (int f = 0; f < vccc_pkg::NUM_FACES; f++) begin
      a = vccc_pkg::FACE_CORNER[f][0];
      b = vccc_pkg::FACE_CORNER[f][1];
      c = vccc_pkg::FACE_CORNER[f][2];
      d = vccc_pkg::FACE_CORNER[f][3];
      s2_eq_nxt[f].ab = s1_lab_r[a] == s1_lab_r[b];
      s2_eq_nxt[f].ac = s1_lab_r[a] == s1_lab_r[c];
      s2_eq_nxt[f].ad = s1_lab_r[a] == s1_lab_r[d];
      s2_eq_nxt[f].bc = s1_lab_r[b] == s1_lab_r[c];
      s2_eq_nxt[f].bd = s1_lab_r[b] == s1_lab_r[d];
      s2_eq_nxt[f].cd = s1_lab_r[c] == s1_lab_r[d];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_edges_r <= s2_edges_nxt;
    for (int f = 0; f < vccc_pkg::NUM_FACES; f++) begin
      s2_eq_r[f] <= s2_eq_nxt[f];
    end
  end

  // face classification
  always_comb begin
    for (int f = 0; f < vccc_pkg::NUM_FACES; f++) begin
      s3_faces_nxt[2*f +: 2] = vccc_pkg::classify_face(s2_eq_r[f]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_edges_r <= s2_edges_r;
    s3_faces_r <= s3_faces_nxt;
  end

  // junction count and vertex type
  always_comb begin
    logic [2:0] junc;
    logic       any_face;
    junc     = 3'd0;
    any_face = 1'b0;
    for (int f = 0; f < vccc_pkg::NUM_FACES; f++) begin
      if (s3_faces_r[2*f +: 2] == vccc_pkg::FACE_JUNCTION) begin
        junc = junc + 3'd1;
      end
      if (s3_faces_r[2*f +: 2] != vccc_pkg::FACE_NONE) begin
        any_face = 1'b1;
      end
    end
    out_word_nxt.edge_crossings = s3_edges_r;
    out_word_nxt.face_types     = s3_faces_r;
    out_word_nxt.junction_count = junc;
    priority if (!any_face) begin
      out_word_nxt.vertex_type = vccc_pkg::VTX_NONE;
    end else if (junc == 3'd0) begin
      out_word_nxt.vertex_type = vccc_pkg::VTX_SURFACE;
    end else if (junc <= 3'd2) begin
      out_word_nxt.vertex_type = vccc_pkg::VTX_EDGE;
    end else begin
      out_word_nxt.vertex_type = vccc_pkg::VTX_CORNER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_valid_r;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/vccc_checker.sv =====
// port checker for the cell classifier and its bind
module vccc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input vccc_pkg::out_word_t out_word,
  input logic                out_valid
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_word_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted word produced no result");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##4 !out_valid)
    else $error("result without an accepted word");

  a_uniform_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_word.edge_crossings == 12'd0)
                   == (out_word.vertex_type == vccc_pkg::VTX_NONE)))
    else $error("vertex type disagrees with edge crossings");

  a_junction_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.vertex_type != vccc_pkg::VTX_NONE) |->
      ((out_word.junction_count == 3'd0) == (out_word.vertex_type == vccc_pkg::VTX_SURFACE)))
    else $error("vertex type disagrees with junction count");

endmodule

bind voxel_cell_crossing_classifier vccc_checker u_vccc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_word  (out_word),
  .out_valid (out_valid)
);

// ===== tb/voxel_cell_crossing_classifier_tb.sv =====
// testbench for the voxel cell crossing classifier: directed and random cells against a predictor
`timescale 1ns / 100ps

module voxel_cell_crossing_classifier_tb;

  localparam int unsigned LABEL_WIDTH = 16;
  localparam int unsigned RANDOM_CELLS = 1200;
  localparam int unsigned DRAIN_CYCLES = 12;

  // corner pairs per edge, corner rings per face
  localparam logic [0:11][2:0] EDGE_LO = {
    3'd0, 3'd1, 3'd0, 3'd2, 3'd4, 3'd5, 3'd4, 3'd6, 3'd0, 3'd1, 3'd3, 3'd2
  };
  localparam logic [0:11][2:0] EDGE_HI = {
    3'd3, 3'd2, 3'd1, 3'd3, 3'd7, 3'd6, 3'd5, 3'd7, 3'd4, 3'd5, 3'd7, 3'd6
  };
  localparam logic [0:5][0:3][2:0] FACE_RING = {
    3'd0, 3'd3, 3'd7, 3'd4,  3'd1, 3'd2, 3'd6, 3'd5,
    3'd0, 3'd1, 3'd5, 3'd4,  3'd3, 3'd2, 3'd6, 3'd7,
    3'd0, 3'd1, 3'd2, 3'd3,  3'd4, 3'd5, 3'd6, 3'd7
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  vccc_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  vccc_pkg::out_word_t out_word;

  vccc_pkg::in_word_t  pending_cells[$];
  vccc_pkg::out_word_t expected_cells[$];
  int unsigned total_cells;
  int unsigned cells_sent;
  int unsigned cells_checked;
  int unsigned corner_cells;
  int unsigned uniform_cells;
  int unsigned error_count;
  int unsigned sender_idle_pct;

  voxel_cell_crossing_classifier #(.LABEL_WIDTH(LABEL_WIDTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic vccc_pkg::face_code_t face_kind(input logic [LABEL_WIDTH-1:0] a,
                                                     input logic [LABEL_WIDTH-1:0] b,
                                                     input logic [LABEL_WIDTH-1:0] c,
                                                     input logic [LABEL_WIDTH-1:0] d);
    int unsigned labels;
    labels = 1;
    if (b != a) labels++;
    if (c != a && c != b) labels++;
    if (d != a && d != b && d != c) labels++;
    if (labels == 1) return vccc_pkg::FACE_NONE;
    if (labels == 2 && !(a == c && b == d)) return vccc_pkg::FACE_SURFACE;
    return vccc_pkg::FACE_JUNCTION;
  endfunction

  function automatic vccc_pkg::out_word_t classify_cell(input vccc_pkg::in_word_t w);
    logic [LABEL_WIDTH-1:0] lab [8];
    logic [LABEL_WIDTH-1:0] mask;
    vccc_pkg::out_word_t res;
    vccc_pkg::face_code_t kind;
    logic any_face;
    int unsigned junctions;
    mask = {LABEL_WIDTH{1'b1}};
    lab[0] = w.label_0 & mask;
    lab[1] = w.label_1 & mask;
    lab[2] = w.label_2 & mask;
    lab[3] = w.label_3 & mask;
    lab[4] = w.label_4 & mask;
    lab[5] = w.label_5 & mask;
    lab[6] = w.label_6 & mask;
    lab[7] = w.label_7 & mask;
    res = '0;
    any_face = 1'b0;
    junctions = 0;
    for (int e = 0; e < 12; e++) begin
      res.edge_crossings[e] = (lab[EDGE_LO[e]] != lab[EDGE_HI[e]]);
    end
    if (res.edge_crossings != '0) begin
      for (int f = 0; f < 6; f++) begin
        kind = face_kind(lab[FACE_RING[f][0]], lab[FACE_RING[f][1]],
                         lab[FACE_RING[f][2]], lab[FACE_RING[f][3]]);
        res.face_types[2*f +: 2] = kind;
        if (kind != vccc_pkg::FACE_NONE) any_face = 1'b1;
        if (kind == vccc_pkg::FACE_JUNCTION) junctions++;
      end
      if (any_face) begin
        if (junctions == 0) res.vertex_type = vccc_pkg::VTX_SURFACE;
        else if (junctions <= 2) res.vertex_type = vccc_pkg::VTX_EDGE;
        else res.vertex_type = vccc_pkg::VTX_CORNER;
      end
      res.junction_count = junctions[2:0];
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_word <= '0;
    end else begin
      if (start && !busy) begin
        expected_cells.push_back(classify_cell(in_word));
        cells_sent++;
      end
      if (cells_sent < total_cells / 3) sender_idle_pct = 17;
      else if (cells_sent < 2 * total_cells / 3) sender_idle_pct = 83;
      else sender_idle_pct = 0;
      if (!start || !busy) begin
        if (pending_cells.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          start <= 1'b1;
          in_word <= pending_cells.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    vccc_pkg::out_word_t exp_word;
    if (rst_n && out_valid) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_word);
        error_count++;
      end else begin
        exp_word = expected_cells.pop_front();
        check_field("edge_crossings", 32'(exp_word.edge_crossings),
                    32'(out_word.edge_crossings));
        check_field("face_types", 32'(exp_word.face_types), 32'(out_word.face_types));
        check_field("vertex_type", 32'(exp_word.vertex_type), 32'(out_word.vertex_type));
        check_field("junction_count", 32'(exp_word.junction_count),
                    32'(out_word.junction_count));
        cells_checked++;
        if (exp_word.vertex_type == vccc_pkg::VTX_CORNER) corner_cells++;
        if (exp_word.edge_crossings == '0) uniform_cells++;
      end
    end
  end

  task automatic queue_random_cell();
    logic [15:0] palette [8];
    logic [15:0] lab [8];
    int unsigned mode;
    int unsigned colors;
    mode = $urandom_range(99, 0);
    colors = (mode < 18) ? $urandom_range(8, 5) : $urandom_range(4, 1);
    palette[0] = 16'($urandom);
    for (int j = 1; j < 8; j++) begin
      if ($urandom_range(1, 0) != 0) palette[j] = 16'($urandom);
      else palette[j] = palette[0] ^ (16'h1 << $urandom_range(15, 0));
    end
    for (int i = 0; i < 8; i++) begin
      if (mode < 10) lab[i] = 16'($urandom);
      else lab[i] = palette[3'($urandom_range(colors - 1, 0))];
    end
    pending_cells.push_back(vccc_pkg::in_word_t'({lab[0], lab[1], lab[2], lab[3],
                                                  lab[4], lab[5], lab[6], lab[7]}));
  endtask

  initial begin
    // uniform cells
    pending_cells.push_back(vccc_pkg::in_word_t'({8{16'h0000}}));
    pending_cells.push_back(vccc_pkg::in_word_t'({8{16'hffff}}));
    pending_cells.push_back(vccc_pkg::in_word_t'({8{16'h1234}}));
    // one odd corner
    pending_cells.push_back(vccc_pkg::in_word_t'({16'hffff, {7{16'h0000}}}));
    pending_cells.push_back(vccc_pkg::in_word_t'({{7{16'h0000}}, 16'hffff}));
    pending_cells.push_back(vccc_pkg::in_word_t'({16'h0000, 16'h8000, {6{16'h0000}}}));
    pending_cells.push_back(vccc_pkg::in_word_t'({{3{16'h7fff}}, 16'h7ffe, {4{16'h7fff}}}));
    // checkerboard: every face has matching diagonals
    pending_cells.push_back(vccc_pkg::in_word_t'({16'h0000, 16'hffff, 16'h0000, 16'hffff,
                                                  16'hffff, 16'h0000, 16'hffff, 16'h0000}));
    pending_cells.push_back(vccc_pkg::in_word_t'({16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                                                  16'h5555, 16'haaaa, 16'h5555, 16'haaaa}));
    // bottom and top layers split
    pending_cells.push_back(vccc_pkg::in_word_t'({{4{16'h0001}}, {4{16'h0002}}}));
    // left and right halves split
    pending_cells.push_back(vccc_pkg::in_word_t'({16'h0000, 16'hffff, 16'hffff, 16'h0000,
                                                  16'h0000, 16'hffff, 16'hffff, 16'h0000}));
    // single diagonal pair matching
    pending_cells.push_back(vccc_pkg::in_word_t'({16'h0003, 16'h0004, 16'h0003, 16'h0003,
                                                  16'h0003, 16'h0003, 16'h0003, 16'h0003}));
    // three labels meeting on two faces
    pending_cells.push_back(vccc_pkg::in_word_t'({16'h0000, 16'h0001, 16'h0002, 16'h0000,
                                                  16'h0000, 16'h0000, 16'h0000, 16'h0000}));
    // three and four labels
    pending_cells.push_back(vccc_pkg::in_word_t'({16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                                  16'h0000, 16'h0001, 16'h0002, 16'h0003}));
    pending_cells.push_back(vccc_pkg::in_word_t'({16'h0000, 16'hffff, 16'h8000, 16'h0000,
                                                  16'h0001, 16'hffff, 16'h8000, 16'h0001}));
    // every corner distinct
    pending_cells.push_back(vccc_pkg::in_word_t'({16'h0000, 16'h0001, 16'h0002, 16'h0004,
                                                  16'h0008, 16'h0010, 16'h0020, 16'hffff}));
    pending_cells.push_back(vccc_pkg::in_word_t'({16'hffff, 16'hfffe, 16'hfffd, 16'hfffb,
                                                  16'hfff7, 16'hffef, 16'hffdf, 16'h0000}));
    // one label per layer column
    pending_cells.push_back(vccc_pkg::in_word_t'({16'h0005, 16'h0006, 16'h0006, 16'h0005,
                                                  16'h0005, 16'h0006, 16'h0006, 16'h0005}));
    pending_cells.push_back(vccc_pkg::in_word_t'({16'h00ff, 16'h00ff, 16'hff00, 16'hff00,
                                                  16'h00ff, 16'h00ff, 16'hff00, 16'hff00}));
    for (int n = 0; n < RANDOM_CELLS; n++) begin
      queue_random_cell();
    end
    total_cells = pending_cells.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cells.size() != 0 || start) @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d of %0d cells: %0d uniform, %0d with corner vertices",
             cells_checked, total_cells, uniform_cells, corner_cells);
    $display("sender gaps at 17 and 83 percent, then back to back");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/vccc_pkg.sv
sv/voxel_cell_crossing_classifier.sv
sv/vccc_checker.sv
tb/voxel_cell_crossing_classifier_tb.sv
